// File: design/rgq_pkg.sv
// Shared types, constants and helpers for the rotated glyph quad setup block.
package rgq_pkg;

  localparam int COORD_W        = 32;
  localparam int UV_W           = 17;
  localparam int TRIG_W         = 18;
  localparam int TRIG_FRAC_BITS = 16;
  localparam int IN_TDATA_W     = 128;
  localparam int IN_TUSER_W     = 2;
  localparam int OUT_TDATA_W    = 104;
  localparam int CFG_INDEX_W    = 3;
  localparam int CFG_DATA_W     = 32;
  localparam int VTX_W          = 3;
  localparam int QUEUE_PTR_W    = 1;
  localparam int QUEUE_DEPTH    = 1 << QUEUE_PTR_W;

  localparam logic [VTX_W-1:0] LAST_VTX = 3'd5;

  // tuser bit positions on the input channel
  localparam int TUSER_START   = 0;
  localparam int TUSER_PRESENT = 1;

  typedef enum logic [CFG_INDEX_W-1:0] {
    REG_SCALE_X     = 3'd0,
    REG_SCALE_Y     = 3'd1,
    REG_COS_ANGLE   = 3'd2,
    REG_SIN_ANGLE   = 3'd3,
    REG_PIVOT_X     = 3'd4,
    REG_PIVOT_Y     = 3'd5,
    REG_PEN_START_X = 3'd6,
    REG_PEN_START_Y = 3'd7
  } cfg_reg_t;

  typedef struct packed {
    logic [31:0]       scale_x;
    logic [31:0]       scale_y;
    logic [TRIG_W-1:0] cos_angle;
    logic [TRIG_W-1:0] sin_angle;
    logic [31:0]       pivot_x;
    logic [31:0]       pivot_y;
    logic [31:0]       pen_start_x;
    logic [31:0]       pen_start_y;
  } cfg_regs_t;

  // Input tdata layout, highest field first (126 bits used of 128).
  typedef struct packed {
    logic [UV_W-1:0] tex_v_bottom;
    logic [UV_W-1:0] tex_u_right;
    logic [UV_W-1:0] tex_v_top;
    logic [UV_W-1:0] tex_u_left;
    logic [15:0]     advance_26_6;
    logic [10:0]     bearing_y;
    logic [10:0]     bearing_x;
    logic [9:0]      bitmap_rows;
    logic [9:0]      bitmap_width;
  } glyph_in_t;

  // One glyph box handed from the front to the back.
  typedef struct packed {
    logic [COORD_W-1:0] x0;
    logic [COORD_W-1:0] x1;
    logic [COORD_W-1:0] y0;
    logic [COORD_W-1:0] y1;
    logic [UV_W-1:0]    u_left;
    logic [UV_W-1:0]    v_top;
    logic [UV_W-1:0]    u_right;
    logic [UV_W-1:0]    v_bottom;
  } quad_t;

  // Corner used by each of the six vertices: p0 p1 p2 p1 p3 p2.
  // Bit 0 picks the right side, bit 1 the bottom side.
  function automatic logic [1:0] vtx_corner(input logic [VTX_W-1:0] k);
    logic [1:0] c;
    unique case (k)
      3'd0:    c = 2'd0;
      3'd1:    c = 2'd1;
      3'd2:    c = 2'd2;
      3'd3:    c = 2'd1;
      3'd4:    c = 2'd3;
      3'd5:    c = 2'd2;
      default: c = 2'd0;
    endcase
    return c;
  endfunction

endpackage

// File: design/rotated_glyph_quad_setup_top.sv
// Top level of the rotated glyph quad setup block: config registers and wiring.
//
//  Channel  Dir  Handshake              Payload
//  in_*     in   in_tvalid/in_tready    one glyph: metrics, advance, atlas UV rect
//  out_*    out  out_tvalid/out_tready  one textured vertex, tlast on the sixth
//  cfg_*    in   cfg_valid/cfg_ready    register index and 32-bit write data
//
// The back emits one vertex per cycle while out_tready is high, six per glyph.
// The front runs each present glyph through five scale products on its shared
// 12x33 multiplier, then the push, and overlaps the next accept with the push.
// A missing glyph returns to idle after its first product and pushes no box.
// Each vertex passes the delta, product and output registers before it leaves.
// Reset is synchronous, active low: it restores the register defaults and
// clears the pen. A stall on out_* freezes the vertex pipeline; the queue lets
// the front keep taking items until it fills.
module rotated_glyph_quad_setup_top #(
  parameter int COORD_FRAC_BITS = 16,
  parameter int SCALE_FRAC_BITS = 24
) (
  input  logic                               clk,
  input  logic                               rst_n,
  // input item channel
  input  logic                               in_tvalid,
  output logic                               in_tready,
  // tdata from bit 0: bitmap_width[9:0], bitmap_rows[19:10], bearing_x[30:20],
  // bearing_y[41:31], advance_26_6[57:42], tex_u_left[74:58],
  // tex_v_top[91:75], tex_u_right[108:92], tex_v_bottom[125:109], zeros
  input  logic [rgq_pkg::IN_TDATA_W-1:0]     in_tdata,
  // tuser from bit 0: start_of_string, glyph_present
  input  logic [rgq_pkg::IN_TUSER_W-1:0]     in_tuser,
  // result channel
  output logic                               out_tvalid,
  input  logic                               out_tready,
  // tdata from bit 0: vertex_x[31:0], vertex_y[63:32], vertex_u[80:64],
  // vertex_v[97:81], zeros
  output logic [rgq_pkg::OUT_TDATA_W-1:0]    out_tdata,
  output logic                               out_tlast,
  // configuration write channel
  input  logic                               cfg_valid,
  output logic                               cfg_ready,
  input  logic [rgq_pkg::CFG_INDEX_W-1:0]    cfg_index,
  input  logic [rgq_pkg::CFG_DATA_W-1:0]     cfg_data
);

  rgq_pkg::cfg_regs_t cfg_r;
  logic               q_wr_valid, q_wr_ready;
  logic               q_rd_valid, q_rd_ready;
  rgq_pkg::quad_t     q_wr_data, q_rd_data;

  // writes are taken in any cycle
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.scale_x     <= 32'd16777216;
      cfg_r.scale_y     <= 32'd16777216;
      cfg_r.cos_angle   <= 18'd65536;
      cfg_r.sin_angle   <= '0;
      cfg_r.pivot_x     <= '0;
      cfg_r.pivot_y     <= '0;
      cfg_r.pen_start_x <= '0;
      cfg_r.pen_start_y <= '0;
    end else if (cfg_valid && cfg_ready) begin
      unique case (rgq_pkg::cfg_reg_t'(cfg_index))
        rgq_pkg::REG_SCALE_X:     cfg_r.scale_x     <= cfg_data;
        rgq_pkg::REG_SCALE_Y:     cfg_r.scale_y     <= cfg_data;
        rgq_pkg::REG_COS_ANGLE:   cfg_r.cos_angle   <= cfg_data[rgq_pkg::TRIG_W-1:0];
        rgq_pkg::REG_SIN_ANGLE:   cfg_r.sin_angle   <= cfg_data[rgq_pkg::TRIG_W-1:0];
        rgq_pkg::REG_PIVOT_X:     cfg_r.pivot_x     <= cfg_data;
        rgq_pkg::REG_PIVOT_Y:     cfg_r.pivot_y     <= cfg_data;
        rgq_pkg::REG_PEN_START_X: cfg_r.pen_start_x <= cfg_data;
        rgq_pkg::REG_PEN_START_Y: cfg_r.pen_start_y <= cfg_data;
      endcase
    end
  end

  // front: pen tracking and box corners
  rgq_front #(
    .COORD_FRAC_BITS (COORD_FRAC_BITS),
    .SCALE_FRAC_BITS (SCALE_FRAC_BITS)
  ) u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .cfg       (cfg_r),
    .q_valid   (q_wr_valid),
    .q_ready   (q_wr_ready),
    .q_data    (q_wr_data)
  );

  // decouple box generation from vertex emission
  rgq_fifo u_fifo (
    .clk      (clk),
    .rst_n    (rst_n),
    .wr_valid (q_wr_valid),
    .wr_ready (q_wr_ready),
    .wr_data  (q_wr_data),
    .rd_valid (q_rd_valid),
    .rd_ready (q_rd_ready),
    .rd_data  (q_rd_data)
  );

  // back: rotation and vertex stream
  rgq_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg        (cfg_r),
    .q_valid    (q_rd_valid),
    .q_ready    (q_rd_ready),
    .q_data     (q_rd_data),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast)
  );

endmodule

// File: design/rgq_front.sv
// Front end: accepts glyph items, keeps the pen and forms the glyph box corners.
module rgq_front #(
  parameter int COORD_FRAC_BITS = 16,
  parameter int SCALE_FRAC_BITS = 24
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 in_tvalid,
  output logic                                 in_tready,
  input  logic [rgq_pkg::IN_TDATA_W-1:0]       in_tdata,
  input  logic [rgq_pkg::IN_TUSER_W-1:0]       in_tuser,
  input  rgq_pkg::cfg_regs_t                   cfg,
  output logic                                 q_valid,
  input  logic                                 q_ready,
  output rgq_pkg::quad_t                       q_data
);

  localparam int RSH = (SCALE_FRAC_BITS >= COORD_FRAC_BITS) ?
                       (SCALE_FRAC_BITS - COORD_FRAC_BITS) : 0;
  localparam int LSH = (SCALE_FRAC_BITS >= COORD_FRAC_BITS) ?
                       0 : (COORD_FRAC_BITS - SCALE_FRAC_BITS);
  localparam int PROD_W = 45;

  // Each multiply state issues one product; the next state folds it into a corner, or the advance into the pen.
  typedef enum logic [2:0] {
    S_IDLE,
    S_MUL_BX,
    S_MUL_W,
    S_MUL_DY,
    S_MUL_ROWS,
    S_MUL_ADV,
    S_PUSH
  } state_t;

  state_t                       state_r;
  rgq_pkg::glyph_in_t           g_r;
  logic                         start_r;
  logic                         present_r;
  logic [31:0]                  pen_r;
  logic [31:0]                  x0_r, x1_r, y0_r, y1_r;
  logic signed [PROD_W-1:0]     prod_r;
  logic signed [PROD_W-1:0]     prod_nxt;
  logic signed [11:0]           op_a;
  logic [31:0]                  op_b;
  logic signed [32:0]           op_b_s;
  logic signed [63:0]           prod_ext;
  logic [31:0]                  scaled;
  logic                         in_acc;

  assign in_tready = (state_r == S_IDLE) || ((state_r == S_PUSH) && q_ready);
  assign in_acc    = in_tvalid && in_tready;

  always_comb begin
    op_a = '0;
    op_b = cfg.scale_x;
    case (state_r)
      S_MUL_BX:   op_a = {g_r.bearing_x[10], g_r.bearing_x};
      S_MUL_W:    op_a = {2'b00, g_r.bitmap_width};
      S_MUL_DY: begin
        op_a = {g_r.bearing_y[10], g_r.bearing_y} - {2'b00, g_r.bitmap_rows};
        op_b = cfg.scale_y;
      end
      S_MUL_ROWS: begin
        op_a = {2'b00, g_r.bitmap_rows};
        op_b = cfg.scale_y;
      end
      S_MUL_ADV:  op_a = {2'b00, g_r.advance_26_6[15:6]};
      default:    op_a = '0;
    endcase
  end

  assign op_b_s   = $signed({1'b0, op_b});
  assign prod_nxt = op_a * op_b_s;

  // Bring pixel count times Q8.24 scale to coordinate format, flooring.
  assign prod_ext = {{(64 - PROD_W){prod_r[PROD_W-1]}}, prod_r};
  assign scaled   = 32'((prod_ext >>> RSH) << LSH);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      pen_r   <= '0;
    end else begin
      if (in_acc) begin
        g_r       <= rgq_pkg::glyph_in_t'(in_tdata[125:0]);
        start_r   <= in_tuser[rgq_pkg::TUSER_START];
        present_r <= in_tuser[rgq_pkg::TUSER_PRESENT];
      end
      if (state_r != S_PUSH) begin
        prod_r <= prod_nxt;
      end
      unique case (state_r)
        S_IDLE: begin
          if (in_acc) begin
            state_r <= S_MUL_BX;
          end
        end
        S_MUL_BX: begin
          // reload happens even for a missing glyph
          if (start_r) begin
            pen_r <= cfg.pen_start_x;
          end
          state_r <= present_r ? S_MUL_W : S_IDLE;
        end
        S_MUL_W: begin
          x0_r    <= pen_r + scaled;
          state_r <= S_MUL_DY;
        end
        S_MUL_DY: begin
          x1_r    <= x0_r + scaled;
          state_r <= S_MUL_ROWS;
        end
        S_MUL_ROWS: begin
          y0_r    <= cfg.pen_start_y + scaled;
          state_r <= S_MUL_ADV;
        end
        S_MUL_ADV: begin
          y1_r    <= y0_r + scaled;
          state_r <= S_PUSH;
        end
        S_PUSH: begin
          // hold until the queue takes the box, then advance the pen
          if (q_ready) begin
            pen_r   <= pen_r + scaled;
            state_r <= in_acc ? S_MUL_BX : S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign q_valid         = (state_r == S_PUSH);
  assign q_data.x0       = x0_r;
  assign q_data.x1       = x1_r;
  assign q_data.y0       = y0_r;
  assign q_data.y1       = y1_r;
  assign q_data.u_left   = g_r.tex_u_left;
  assign q_data.v_top    = g_r.tex_v_top;
  assign q_data.u_right  = g_r.tex_u_right;
  assign q_data.v_bottom = g_r.tex_v_bottom;

endmodule

// File: design/rgq_fifo.sv
// Small queue of glyph boxes between the front and the back.
module rgq_fifo (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           wr_valid,
  output logic           wr_ready,
  input  rgq_pkg::quad_t wr_data,
  output logic           rd_valid,
  input  logic           rd_ready,
  output rgq_pkg::quad_t rd_data
);

  rgq_pkg::quad_t                   mem_r [rgq_pkg::QUEUE_DEPTH];
  logic [rgq_pkg::QUEUE_PTR_W-1:0]  wptr_r, rptr_r;
  logic [rgq_pkg::QUEUE_PTR_W:0]    cnt_r;
  logic                             push, pop;

  assign wr_ready = (cnt_r != (rgq_pkg::QUEUE_PTR_W + 1)'(rgq_pkg::QUEUE_DEPTH));
  assign rd_valid = (cnt_r != '0);
  assign push     = wr_valid && wr_ready;
  assign pop      = rd_valid && rd_ready;
  assign rd_data  = mem_r[rptr_r];

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wptr_r] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wptr_r <= '0;
      rptr_r <= '0;
      cnt_r  <= '0;
    end else begin
      if (push) begin
        wptr_r <= wptr_r + 1'b1;
      end
      if (pop) begin
        rptr_r <= rptr_r + 1'b1;
      end
      if (push && !pop) begin
        cnt_r <= cnt_r + 1'b1;
      end else if (pop && !push) begin
        cnt_r <= cnt_r - 1'b1;
      end
    end
  end

endmodule

// File: design/rgq_back.sv
// Back end: rotates corners about the pivot and emits six vertices per glyph.
module rgq_back (
  input  logic                              clk,
  input  logic                              rst_n,
  input  rgq_pkg::cfg_regs_t                cfg,
  input  logic                              q_valid,
  output logic                              q_ready,
  input  rgq_pkg::quad_t                    q_data,
  output logic                              out_tvalid,
  input  logic                              out_tready,
  output logic [rgq_pkg::OUT_TDATA_W-1:0]   out_tdata,
  output logic                              out_tlast
);

  localparam int PW = 32 + rgq_pkg::TRIG_W;

  logic [rgq_pkg::VTX_W-1:0]  vidx_r;
  logic                       en;
  logic [1:0]                 corner;
  logic [31:0]                sel_x, sel_y;
  logic [rgq_pkg::UV_W-1:0]   sel_u, sel_v;

  // stage 1: deltas to the pivot
  logic                       s1_vld_r;
  logic signed [31:0]         dx_r, dy_r;
  logic [rgq_pkg::UV_W-1:0]   u1_r, v1_r;
  logic                       last1_r;

  // stage 2: floored products
  logic                       s2_vld_r;
  logic [31:0]                xc_r, ys_r, xs_r, yc_r;
  logic [rgq_pkg::UV_W-1:0]   u2_r, v2_r;
  logic                       last2_r;

  // stage 3: output register
  logic                       s3_vld_r;
  logic [31:0]                vx_r, vy_r;
  logic [rgq_pkg::UV_W-1:0]   u3_r, v3_r;
  logic                       last3_r;

  logic signed [PW-1:0]       p_xc, p_ys, p_xs, p_yc;

  // the whole line moves together whenever the output slot frees up
  assign en      = !s3_vld_r || out_tready;
  assign q_ready = en && q_valid && (vidx_r == rgq_pkg::LAST_VTX);

  assign corner = rgq_pkg::vtx_corner(vidx_r);
  assign sel_x  = corner[0] ? q_data.x1 : q_data.x0;
  assign sel_y  = corner[1] ? q_data.y1 : q_data.y0;
  assign sel_u  = corner[0] ? q_data.u_right : q_data.u_left;
  assign sel_v  = corner[1] ? q_data.v_bottom : q_data.v_top;

  assign p_xc = dx_r * $signed(cfg.cos_angle);
  assign p_ys = dy_r * $signed(cfg.sin_angle);
  assign p_xs = dx_r * $signed(cfg.sin_angle);
  assign p_yc = dy_r * $signed(cfg.cos_angle);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vidx_r   <= '0;
      s1_vld_r <= 1'b0;
      s2_vld_r <= 1'b0;
      s3_vld_r <= 1'b0;
    end else if (en) begin
      s1_vld_r <= q_valid;
      s2_vld_r <= s1_vld_r;
      s3_vld_r <= s2_vld_r;
      if (q_valid) begin
        vidx_r <= (vidx_r == rgq_pkg::LAST_VTX) ? '0 : vidx_r + 1'b1;
      end

      dx_r    <= sel_x - cfg.pivot_x;
      dy_r    <= sel_y - cfg.pivot_y;
      u1_r    <= sel_u;
      v1_r    <= sel_v;
      last1_r <= (vidx_r == rgq_pkg::LAST_VTX);

      xc_r    <= p_xc[rgq_pkg::TRIG_FRAC_BITS +: 32];
      ys_r    <= p_ys[rgq_pkg::TRIG_FRAC_BITS +: 32];
      xs_r    <= p_xs[rgq_pkg::TRIG_FRAC_BITS +: 32];
      yc_r    <= p_yc[rgq_pkg::TRIG_FRAC_BITS +: 32];
      u2_r    <= u1_r;
      v2_r    <= v1_r;
      last2_r <= last1_r;

      vx_r    <= cfg.pivot_x + xc_r - ys_r;
      vy_r    <= cfg.pivot_y + xs_r + yc_r;
      u3_r    <= u2_r;
      v3_r    <= v2_r;
      last3_r <= last2_r;
    end
  end

  assign out_tvalid = s3_vld_r;
  assign out_tdata  = {6'b0, v3_r, u3_r, vy_r, vx_r};
  assign out_tlast  = last3_r;

endmodule
